FILE: sv/g3_fax_run_length_decoder_macros.svh
// ---------------------------------------------------------------------------
// g3_fax_run_length_decoder_macros
// Assertion macros for the decoder RTL.
// ---------------------------------------------------------------------------
`ifndef G3_FAX_RUN_LENGTH_DECODER_MACROS_SVH
`define G3_FAX_RUN_LENGTH_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define G3RL_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("g3 fax decoder check failed");
`define G3RL_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("g3 fax decoder check failed");
`else
`define G3RL_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define G3RL_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

FILE: sv/g3rl_pkg.sv
// ---------------------------------------------------------------------------
// g3rl_pkg
// Types, constants and T.4 code tables for the Group 3 run decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package g3rl_pkg;

  localparam int MAX_COLUMNS  = 2048;
  localparam int MAX_CODE_LEN = 13;
  localparam int EOL_ZEROS    = 11;
  localparam int PENDING_MAX  = 16383;
  localparam int CFG_AW       = 4;

  localparam logic [11:0] NO_RUN = 12'hFFF;

  typedef enum logic [1:0] {
    REG_LSB_FIRST     = 2'd0,
    REG_LINE_WIDTH    = 2'd1,
    REG_END_ROW_COUNT = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    EV_RUN      = 3'd0,
    EV_EOL      = 3'd1,
    EV_BAD_CODE = 3'd2,
    EV_ROW_FULL = 3'd3,
    EV_PAGE_END = 3'd4
  } ev_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] bits;
  } q_t;

  typedef struct packed {
    ev_t         ev;
    logic        black;
    logic [10:0] start;
    logic [11:0] len;
    logic [11:0] width;
  } res_t;

  function automatic logic [11:0] white_run(input logic [3:0] l, input logic [12:0] c);
    logic [11:0] r;
    r = NO_RUN;
    case ({l, c})
      {4'd8,13'h35}: r = 12'd0;    {4'd6,13'h07}: r = 12'd1;    {4'd4,13'h7}: r = 12'd2;
      {4'd4,13'h8}: r = 12'd3;     {4'd4,13'hB}: r = 12'd4;     {4'd4,13'hC}: r = 12'd5;
      {4'd4,13'hE}: r = 12'd6;     {4'd4,13'hF}: r = 12'd7;     {4'd5,13'h13}: r = 12'd8;
      {4'd5,13'h14}: r = 12'd9;    {4'd5,13'h07}: r = 12'd10;   {4'd5,13'h08}: r = 12'd11;
      {4'd6,13'h08}: r = 12'd12;   {4'd6,13'h03}: r = 12'd13;   {4'd6,13'h34}: r = 12'd14;
      {4'd6,13'h35}: r = 12'd15;   {4'd6,13'h2A}: r = 12'd16;   {4'd6,13'h2B}: r = 12'd17;
      {4'd7,13'h27}: r = 12'd18;   {4'd7,13'h0C}: r = 12'd19;   {4'd7,13'h08}: r = 12'd20;
      {4'd7,13'h17}: r = 12'd21;   {4'd7,13'h03}: r = 12'd22;   {4'd7,13'h04}: r = 12'd23;
      {4'd7,13'h28}: r = 12'd24;   {4'd7,13'h2B}: r = 12'd25;   {4'd7,13'h13}: r = 12'd26;
      {4'd7,13'h24}: r = 12'd27;   {4'd7,13'h18}: r = 12'd28;   {4'd8,13'h02}: r = 12'd29;
      {4'd8,13'h03}: r = 12'd30;   {4'd8,13'h1A}: r = 12'd31;   {4'd8,13'h1B}: r = 12'd32;
      {4'd8,13'h12}: r = 12'd33;   {4'd8,13'h13}: r = 12'd34;   {4'd8,13'h14}: r = 12'd35;
      {4'd8,13'h15}: r = 12'd36;   {4'd8,13'h16}: r = 12'd37;   {4'd8,13'h17}: r = 12'd38;
      {4'd8,13'h28}: r = 12'd39;   {4'd8,13'h29}: r = 12'd40;   {4'd8,13'h2A}: r = 12'd41;
      {4'd8,13'h2B}: r = 12'd42;   {4'd8,13'h2C}: r = 12'd43;   {4'd8,13'h2D}: r = 12'd44;
      {4'd8,13'h04}: r = 12'd45;   {4'd8,13'h05}: r = 12'd46;   {4'd8,13'h0A}: r = 12'd47;
      {4'd8,13'h0B}: r = 12'd48;   {4'd8,13'h52}: r = 12'd49;   {4'd8,13'h53}: r = 12'd50;
      {4'd8,13'h54}: r = 12'd51;   {4'd8,13'h55}: r = 12'd52;   {4'd8,13'h24}: r = 12'd53;
      {4'd8,13'h25}: r = 12'd54;   {4'd8,13'h58}: r = 12'd55;   {4'd8,13'h59}: r = 12'd56;
      {4'd8,13'h5A}: r = 12'd57;   {4'd8,13'h5B}: r = 12'd58;   {4'd8,13'h4A}: r = 12'd59;
      {4'd8,13'h4B}: r = 12'd60;   {4'd8,13'h32}: r = 12'd61;   {4'd8,13'h33}: r = 12'd62;
      {4'd8,13'h34}: r = 12'd63;
      {4'd5,13'h1B}: r = 12'd64;   {4'd5,13'h12}: r = 12'd128;  {4'd6,13'h17}: r = 12'd192;
      {4'd7,13'h37}: r = 12'd256;  {4'd8,13'h36}: r = 12'd320;  {4'd8,13'h37}: r = 12'd384;
      {4'd8,13'h64}: r = 12'd448;  {4'd8,13'h65}: r = 12'd512;  {4'd8,13'h68}: r = 12'd576;
      {4'd8,13'h67}: r = 12'd640;  {4'd9,13'hCC}: r = 12'd704;  {4'd9,13'hCD}: r = 12'd768;
      {4'd9,13'hD2}: r = 12'd832;  {4'd9,13'hD3}: r = 12'd896;  {4'd9,13'hD4}: r = 12'd960;
      {4'd9,13'hD5}: r = 12'd1024; {4'd9,13'hD6}: r = 12'd1088; {4'd9,13'hD7}: r = 12'd1152;
      {4'd9,13'hD8}: r = 12'd1216; {4'd9,13'hD9}: r = 12'd1280; {4'd9,13'hDA}: r = 12'd1344;
      {4'd9,13'hDB}: r = 12'd1408; {4'd9,13'h98}: r = 12'd1472; {4'd9,13'h99}: r = 12'd1536;
      {4'd9,13'h9A}: r = 12'd1600; {4'd6,13'h18}: r = 12'd1664; {4'd9,13'h9B}: r = 12'd1728;
      default: r = NO_RUN;
    endcase
    return r;
  endfunction

  function automatic logic [11:0] black_run(input logic [3:0] l, input logic [12:0] c);
    logic [11:0] r;
    r = NO_RUN;
    case ({l, c})
      {4'd10,13'h37}: r = 12'd0;   {4'd3,13'h2}: r = 12'd1;     {4'd2,13'h3}: r = 12'd2;
      {4'd2,13'h2}: r = 12'd3;     {4'd3,13'h3}: r = 12'd4;     {4'd4,13'h3}: r = 12'd5;
      {4'd4,13'h2}: r = 12'd6;     {4'd5,13'h3}: r = 12'd7;     {4'd6,13'h5}: r = 12'd8;
      {4'd6,13'h4}: r = 12'd9;     {4'd7,13'h4}: r = 12'd10;    {4'd7,13'h5}: r = 12'd11;
      {4'd7,13'h7}: r = 12'd12;    {4'd8,13'h4}: r = 12'd13;    {4'd8,13'h7}: r = 12'd14;
      {4'd9,13'h18}: r = 12'd15;   {4'd10,13'h17}: r = 12'd16;  {4'd10,13'h18}: r = 12'd17;
      {4'd10,13'h08}: r = 12'd18;  {4'd11,13'h67}: r = 12'd19;  {4'd11,13'h68}: r = 12'd20;
      {4'd11,13'h6C}: r = 12'd21;  {4'd11,13'h37}: r = 12'd22;  {4'd11,13'h28}: r = 12'd23;
      {4'd11,13'h17}: r = 12'd24;  {4'd11,13'h18}: r = 12'd25;  {4'd12,13'hCA}: r = 12'd26;
      {4'd12,13'hCB}: r = 12'd27;  {4'd12,13'hCC}: r = 12'd28;  {4'd12,13'hCD}: r = 12'd29;
      {4'd12,13'h68}: r = 12'd30;  {4'd12,13'h69}: r = 12'd31;  {4'd12,13'h6A}: r = 12'd32;
      {4'd12,13'h6B}: r = 12'd33;  {4'd12,13'hD2}: r = 12'd34;  {4'd12,13'hD3}: r = 12'd35;
      {4'd12,13'hD4}: r = 12'd36;  {4'd12,13'hD5}: r = 12'd37;  {4'd12,13'hD6}: r = 12'd38;
      {4'd12,13'hD7}: r = 12'd39;  {4'd12,13'h6C}: r = 12'd40;  {4'd12,13'h6D}: r = 12'd41;
      {4'd12,13'hDA}: r = 12'd42;  {4'd12,13'hDB}: r = 12'd43;  {4'd12,13'h54}: r = 12'd44;
      {4'd12,13'h55}: r = 12'd45;  {4'd12,13'h56}: r = 12'd46;  {4'd12,13'h57}: r = 12'd47;
      {4'd12,13'h64}: r = 12'd48;  {4'd12,13'h65}: r = 12'd49;  {4'd12,13'h52}: r = 12'd50;
      {4'd12,13'h53}: r = 12'd51;  {4'd12,13'h24}: r = 12'd52;  {4'd12,13'h37}: r = 12'd53;
      {4'd12,13'h38}: r = 12'd54;  {4'd12,13'h27}: r = 12'd55;  {4'd12,13'h28}: r = 12'd56;
      {4'd12,13'h58}: r = 12'd57;  {4'd12,13'h59}: r = 12'd58;  {4'd12,13'h2B}: r = 12'd59;
      {4'd12,13'h2C}: r = 12'd60;  {4'd12,13'h5A}: r = 12'd61;  {4'd12,13'h66}: r = 12'd62;
      {4'd12,13'h67}: r = 12'd63;
      {4'd10,13'h0F}: r = 12'd64;  {4'd12,13'hC8}: r = 12'd128; {4'd12,13'hC9}: r = 12'd192;
      {4'd12,13'h5B}: r = 12'd256; {4'd12,13'h33}: r = 12'd320; {4'd12,13'h34}: r = 12'd384;
      {4'd12,13'h35}: r = 12'd448; {4'd13,13'h6C}: r = 12'd512; {4'd13,13'h6D}: r = 12'd576;
      {4'd13,13'h4A}: r = 12'd640; {4'd13,13'h4B}: r = 12'd704; {4'd13,13'h4C}: r = 12'd768;
      {4'd13,13'h4D}: r = 12'd832; {4'd13,13'h72}: r = 12'd896; {4'd13,13'h73}: r = 12'd960;
      {4'd13,13'h74}: r = 12'd1024; {4'd13,13'h75}: r = 12'd1088;
      {4'd13,13'h76}: r = 12'd1152; {4'd13,13'h77}: r = 12'd1216;
      {4'd13,13'h52}: r = 12'd1280; {4'd13,13'h53}: r = 12'd1344;
      {4'd13,13'h54}: r = 12'd1408; {4'd13,13'h55}: r = 12'd1472;
      {4'd13,13'h5A}: r = 12'd1536; {4'd13,13'h5B}: r = 12'd1600;
      {4'd13,13'h64}: r = 12'd1664; {4'd13,13'h65}: r = 12'd1728;
      default: r = NO_RUN;
    endcase
    return r;
  endfunction

  function automatic logic [11:0] ext_run(input logic [3:0] l, input logic [12:0] c);
    logic [11:0] r;
    r = NO_RUN;
    case ({l, c})
      {4'd11,13'h08}: r = 12'd1792; {4'd11,13'h0C}: r = 12'd1856;
      {4'd11,13'h0D}: r = 12'd1920; {4'd12,13'h12}: r = 12'd1984;
      {4'd12,13'h13}: r = 12'd2048; {4'd12,13'h14}: r = 12'd2112;
      {4'd12,13'h15}: r = 12'd2176; {4'd12,13'h16}: r = 12'd2240;
      {4'd12,13'h17}: r = 12'd2304; {4'd12,13'h1C}: r = 12'd2368;
      {4'd12,13'h1D}: r = 12'd2432; {4'd12,13'h1E}: r = 12'd2496;
      {4'd12,13'h1F}: r = 12'd2560;
      default: r = NO_RUN;
    endcase
    return r;
  endfunction

  function automatic logic [11:0] code_lookup(input logic [3:0] l, input logic [12:0] c,
                                              input logic white);
    logic [11:0] r;
    r = white ? white_run(l, c) : black_run(l, c);
    if (r == NO_RUN) begin
      r = ext_run(l, c);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/g3rl_front.sv
// ---------------------------------------------------------------------------
// g3rl_front
// Byte intake: orients bits to code order and queues bytes for the decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module g3rl_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          lsb_first,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    data_byte,
  output g3rl_pkg::q_t       q,
  input  wire logic          q_pop
);
  import g3rl_pkg::*;

  logic [7:0] mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [7:0] oriented;
  logic       push;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      oriented[i] = lsb_first ? data_byte[7 - i] : data_byte[i];
    end
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q.valid  = (count != 2'd0);
  assign q.bits   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= oriented;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

`default_nettype wire

FILE: sv/g3rl_back.sv
// ---------------------------------------------------------------------------
// g3rl_back
// Bit-serial modified Huffman decode, row/page tracking and result output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "g3_fax_run_length_decoder_macros.svh"

module g3rl_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [11:0]   width,
  input  wire logic [2:0]    erc,
  input  wire g3rl_pkg::q_t  q,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output g3rl_pkg::res_t     out_res,
  output logic               out_last
);
  import g3rl_pkg::*;

  logic        busy;
  logic [3:0]  bit_idx, bit_idx_next;
  logic [7:0]  byte_r, byte_r_next;
  logic        full_pend, full_pend_next;
  logic [13:0] code_bits, code_bits_next;
  logic [3:0]  code_length, code_length_next;
  logic        white_turn, white_turn_next;
  logic [11:0] column, column_next;
  logic [13:0] pending_count, pending_count_next;
  logic [3:0]  zero_run, zero_run_next;
  logic [2:0]  empty_eols, empty_eols_next;
  logic        skip_to_eol, skip_to_eol_next;
  logic        page_done, page_done_next;

  res_t        held;
  logic        held_valid;
  logic        emit;
  res_t        emit_res;
  logic        fin;
  logic        stall;
  logic        push;
  logic        can_push;

  assign can_push = !out_valid || out_ready;
  assign stall    = (emit || fin) && held_valid && !can_push;
  assign push     = (emit || fin) && held_valid && !stall;
  assign q_pop    = q.valid && (!busy || (fin && !stall));

  always_comb begin
    logic        b;
    logic        eol;
    logic [13:0] cbn;
    logic [3:0]  cln;
    logic [11:0] lrun;
    logic [14:0] sum;
    logic [11:0] room;
    logic [11:0] total;
    logic [11:0] coln;
    logic [2:0]  ee_inc;

    b      = byte_r[7];
    eol    = b && (zero_run >= 4'(EOL_ZEROS));
    cbn    = {code_bits[12:0], b};
    cln    = (code_length < 4'd15) ? code_length + 4'd1 : 4'd15;
    lrun   = code_lookup(cln, cbn[12:0], white_turn);
    sum    = {1'b0, pending_count} + {3'b000, lrun};
    room   = (width > column) ? width - column : 12'd0;
    total  = (sum > {3'b000, room}) ? room : sum[11:0];
    coln   = column + total;
    ee_inc = (empty_eols < 3'd7) ? empty_eols + 3'd1 : 3'd7;

    bit_idx_next       = bit_idx;
    byte_r_next        = byte_r;
    full_pend_next     = full_pend;
    code_bits_next     = code_bits;
    code_length_next   = code_length;
    white_turn_next    = white_turn;
    column_next        = column;
    pending_count_next = pending_count;
    zero_run_next      = zero_run;
    empty_eols_next    = empty_eols;
    skip_to_eol_next   = skip_to_eol;
    page_done_next     = page_done;
    emit               = 1'b0;
    emit_res           = '0;
    fin                = 1'b0;

    if (busy) begin
      if (full_pend) begin
        emit           = 1'b1;
        emit_res.ev    = EV_ROW_FULL;
        emit_res.width = column;
        full_pend_next = 1'b0;
      end else if (page_done || bit_idx == 4'd8) begin
        fin = 1'b1;
      end else begin
        bit_idx_next  = bit_idx + 4'd1;
        byte_r_next   = {byte_r[6:0], 1'b0};
        zero_run_next = b ? 4'd0 :
                        (zero_run < 4'(EOL_ZEROS) ? zero_run + 4'd1 : 4'(EOL_ZEROS));
        if (skip_to_eol) begin
          if (eol) begin
            skip_to_eol_next   = 1'b0;
            code_bits_next     = '0;
            code_length_next   = '0;
            white_turn_next    = 1'b1;
            column_next        = '0;
            pending_count_next = '0;
          end
        end else if (eol) begin
          emit = 1'b1;
          if (column == 12'd0) begin
            empty_eols_next = ee_inc;
          end else begin
            empty_eols_next = 3'd0;
          end
          if (column == 12'd0 && ee_inc >= erc) begin
            page_done_next = 1'b1;
            emit_res.ev    = EV_PAGE_END;
          end else begin
            emit_res.ev        = EV_EOL;
            emit_res.width     = column;
            code_bits_next     = '0;
            code_length_next   = '0;
            white_turn_next    = 1'b1;
            column_next        = '0;
            pending_count_next = '0;
          end
        end else begin
          code_bits_next   = cbn;
          code_length_next = cln;
          if (cbn != 14'd0) begin
            if (cln > 4'(MAX_CODE_LEN)) begin
              emit             = 1'b1;
              emit_res.ev      = EV_BAD_CODE;
              emit_res.width   = column;
              skip_to_eol_next = 1'b1;
            end else if (lrun != NO_RUN) begin
              code_bits_next   = '0;
              code_length_next = '0;
              if (lrun >= 12'd64) begin
                pending_count_next = (sum > 15'(PENDING_MAX)) ? 14'(PENDING_MAX) : sum[13:0];
              end else begin
                pending_count_next = '0;
                column_next        = coln;
                white_turn_next    = ~white_turn;
                if (total != 12'd0) begin
                  emit           = 1'b1;
                  emit_res.ev    = EV_RUN;
                  emit_res.black = ~white_turn;
                  emit_res.start = column[10:0];
                  emit_res.len   = total;
                  if (coln >= width) begin
                    full_pend_next   = 1'b1;
                    skip_to_eol_next = 1'b1;
                  end
                end else if (coln >= width) begin
                  emit             = 1'b1;
                  emit_res.ev      = EV_ROW_FULL;
                  emit_res.width   = coln;
                  skip_to_eol_next = 1'b1;
                end
              end
            end
          end
        end
        if (bit_idx == 4'd7 && !emit) begin
          fin = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_res  <= held;
      out_last <= fin;
    end
    if (emit && !stall) begin
      held <= emit_res;
    end
    if (q_pop) begin
      byte_r <= q.bits;
    end else if (!stall) begin
      byte_r <= byte_r_next;
    end
    if (rst) begin
      busy          <= 1'b0;
      bit_idx       <= 4'd0;
      full_pend     <= 1'b0;
      code_bits     <= '0;
      code_length   <= '0;
      white_turn    <= 1'b1;
      column        <= '0;
      pending_count <= '0;
      zero_run      <= '0;
      empty_eols    <= '0;
      skip_to_eol   <= 1'b1;
      page_done     <= 1'b0;
      held_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (q_pop) begin
        busy    <= 1'b1;
        bit_idx <= 4'd0;
      end else if (!stall) begin
        bit_idx <= bit_idx_next;
        if (fin) begin
          busy <= 1'b0;
        end
      end
      if (!stall) begin
        full_pend     <= full_pend_next;
        code_bits     <= code_bits_next;
        code_length   <= code_length_next;
        white_turn    <= white_turn_next;
        column        <= column_next;
        pending_count <= pending_count_next;
        zero_run      <= zero_run_next;
        empty_eols    <= empty_eols_next;
        skip_to_eol   <= skip_to_eol_next;
        page_done     <= page_done_next;
        if (emit) begin
          held_valid <= 1'b1;
        end else if (fin) begin
          held_valid <= 1'b0;
        end
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `G3RL_ASSERT_IMP(a_full_pend_busy, clk, rst, full_pend, busy)
  `G3RL_ASSERT_NXT(a_page_sticky, clk, rst, page_done, page_done)
  `G3RL_ASSERT_IMP(a_bit_range, clk, rst, busy, bit_idx <= 4'd8)

endmodule

`default_nettype wire

FILE: sv/g3_fax_run_length_decoder.sv
// ---------------------------------------------------------------------------
// g3_fax_run_length_decoder
// Group 3 one-dimensional modified Huffman run decoder with APB setup.
// ---------------------------------------------------------------------------
// Each accepted byte is decoded one code bit per clock unless the output
// stalls; a finish step follows when the last bit yields a result, and a
// row-full result follows a run that fills the row. A two-beat byte queue
// and an output register let intake and output stall independently.
`timescale 1ns / 1ps
`default_nettype none

module g3_fax_run_length_decoder (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [g3rl_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [7:0]                data_byte,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [2:0]                     event_res,
  output logic                           run_black,
  output logic [10:0]                    run_start,
  output logic [11:0]                    run_length,
  output logic [11:0]                    row_width,
  output logic                           last_of_byte
);
  import g3rl_pkg::*;

  logic        lsb_first;
  logic [11:0] line_width;
  logic [2:0]  end_row_count;
  logic [11:0] width_eff;
  logic        wr_en;
  reg_idx_t    idx;
  q_t          q;
  logic        q_pop;
  res_t        res;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_comb begin
    case (idx)
      REG_LSB_FIRST:     prdata = {31'd0, lsb_first};
      REG_LINE_WIDTH:    prdata = {20'd0, line_width};
      REG_END_ROW_COUNT: prdata = {29'd0, end_row_count};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lsb_first     <= 1'b0;
      line_width    <= 12'd1728;
      end_row_count <= 3'd3;
    end else if (wr_en) begin
      case (idx)
        REG_LSB_FIRST:     lsb_first     <= pwdata[0];
        REG_LINE_WIDTH:    line_width    <= pwdata[11:0];
        REG_END_ROW_COUNT: end_row_count <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  assign width_eff = (line_width == 12'd0) ? 12'd1 :
                     (line_width > 12'(MAX_COLUMNS)) ? 12'(MAX_COLUMNS) : line_width;

  g3rl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .lsb_first (lsb_first),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .q         (q),
    .q_pop     (q_pop)
  );

  g3rl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .width     (width_eff),
    .erc       (end_row_count),
    .q         (q),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res),
    .out_last  (last_of_byte)
  );

  assign event_res  = res.ev;
  assign run_black  = res.black;
  assign run_start  = res.start;
  assign run_length = res.len;
  assign row_width  = res.width;

endmodule

`default_nettype wire
